// ===== hdl/slfp_pkg.sv =====
// ---------------------------------------------------------------------------
// slfp_pkg: shared types and constants of the sensor log frame parser
// Holds the result item layout, the result kind codes, byte codes of the
// record framing and the default sizes handed to the modules.
// ---------------------------------------------------------------------------
package slfp_pkg;

  // Default number of ADC samples in one record.
  localparam int AdcChannelsDefault = 8;
  // Width of the ADC index register; covers up to sixteen channels.
  localparam int AdcIdxW = 4;
  // Depth of the queue between the parser and the output stage.
  localparam int QueueDepthDefault = 4;

  localparam int ByteW  = 8;
  localparam int ValueW = 16;
  localparam int ChanW  = 3;
  localparam int KindW  = 2;
  localparam int CountW = 32;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;

  // Packed widths of the output stream groups.
  localparam int OutDataW = 24;
  localparam int OutUserW = KindW;

  // Result kinds.
  localparam logic [KindW-1:0] KIND_ADC  = 2'd0;
  localparam logic [KindW-1:0] KIND_TEXT = 2'd1;
  localparam logic [KindW-1:0] KIND_END  = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_FORMAT_TWO = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_STREAM_END = 2'd1;

  // Framing bytes.
  localparam logic [ByteW-1:0] CH_START  = 8'h21;
  localparam logic [ByteW-1:0] CH_OPEN2  = 8'h82;
  localparam logic [ByteW-1:0] CH_CLOSE2 = 8'h83;
  localparam logic [ByteW-1:0] CH_STOP   = 8'h23;
  localparam logic [ByteW-1:0] CH_DOLLAR = 8'h24;
  localparam logic [ByteW-1:0] CH_STAR   = 8'h2A;
  localparam logic [ByteW-1:0] CH_CR     = 8'h0D;
  localparam logic [ByteW-1:0] CH_LF     = 8'h0A;

  // One result item as it travels through the queue.
  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [ValueW-1:0] value;
    logic [ChanW-1:0]  channel;
    logic              separator_before;
  } result_t;

  // Push side of the queue, driven by the parser.
  typedef struct packed {
    logic    push;
    result_t item;
  } push_t;

endpackage

// ===== hdl/sensor_log_frame_parser_core.sv =====
// ---------------------------------------------------------------------------
// sensor_log_frame_parser_core: sensor log record deframer
// Deframes log records from a byte stream into ADC samples, GPS text
// characters and record ends.
//
//   Channel  Direction  Ports                          Content
//   in_      slave      tvalid tready tdata[7:0]       one log byte
//   out_     master     tvalid tready tdata tuser      one result item
//   cfg_     slave      valid ready index data         register write
//
// One byte is taken per cycle while the queue is not full; its result enters
// the queue at the same edge that takes the byte and then passes through the
// output register, where it is held until the output side takes it.
// Reset is synchronous and active low; it clears control state, presets registers.
// in_tready falls only when the queue (four entries by default) is full, so a
// stalled output side holds up the input after five pending results, one of
// them in the output register.
// The configuration port is always ready.
// ---------------------------------------------------------------------------
module sensor_log_frame_parser_core #(
  parameter int ADC_CHANNELS = slfp_pkg::AdcChannelsDefault,
  parameter int QUEUE_DEPTH  = slfp_pkg::QueueDepthDefault
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // tdata: byte_value [7:0]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,
  // tdata: value [15:0], channel [18:16], separator_before [19], zero [23:20]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [slfp_pkg::OutDataW-1:0]     out_tdata,
  // tuser: kind [1:0]
  output logic [slfp_pkg::OutUserW-1:0]     out_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [slfp_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [slfp_pkg::CfgDataW-1:0]     cfg_data
);
  import slfp_pkg::*;

  logic              format_two_r;
  logic [CountW-1:0] stream_end_r;
  logic              accept;
  logic              full;
  logic              empty;
  logic              pop;
  push_t             push;
  result_t           head;

  assign cfg_ready = 1'b1;
  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_two_r <= 1'b1;
      stream_end_r <= {CountW{1'b1}};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FORMAT_TWO: format_two_r <= cfg_data[0];
        REG_STREAM_END: stream_end_r <= cfg_data[CountW-1:0];
        default: ;
      endcase
    end
  end

  slfp_front #(
    .ADC_CHANNELS(ADC_CHANNELS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .byte_value (in_tdata),
    .format_two (format_two_r),
    .stream_end (stream_end_r),
    .push_o     (push)
  );

  slfp_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (push),
    .pop    (pop),
    .full   (full),
    .empty  (empty),
    .head   (head)
  );

  slfp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== hdl/slfp_front.sv =====
// ---------------------------------------------------------------------------
// slfp_front: byte classifier and record state machine
// Accepts one log byte per cycle while accept is high, tracks the record phase
// and produces at most one result item per byte into the queue.
// ---------------------------------------------------------------------------
module slfp_front #(
  parameter int ADC_CHANNELS = slfp_pkg::AdcChannelsDefault
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [slfp_pkg::ByteW-1:0]    byte_value,
  input  logic                          format_two,
  input  logic [slfp_pkg::CountW-1:0]   stream_end,
  output slfp_pkg::push_t               push_o
);
  import slfp_pkg::*;

  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_WAIT_OPEN  = 3'd1;
  localparam logic [2:0] PH_ADC        = 3'd2;
  localparam logic [2:0] PH_SKIP       = 3'd3;
  localparam logic [2:0] PH_SEARCH     = 3'd4;
  localparam logic [2:0] PH_TEXT       = 3'd5;
  localparam logic [2:0] PH_WAIT_CLOSE = 3'd6;

  localparam logic [AdcIdxW-1:0] LastIdx = AdcIdxW'(ADC_CHANNELS - 1);

  logic [2:0]         phase_r, phase_nxt;
  logic [ByteW-1:0]   hold_r, hold_nxt;
  logic [AdcIdxW-1:0] idx_r, idx_nxt;
  logic               pend_r, pend_nxt;
  logic               seen_r, seen_nxt;
  logic [CountW-1:0]  cnt_r, cnt_nxt;

  logic    live;
  logic    do_text;
  logic    do_stop;
  logic    do_close;
  push_t   push_c;

  assign cnt_nxt = (accept && cnt_r != {CountW{1'b1}}) ? cnt_r + 1'b1 : cnt_r;
  assign live    = accept && (cnt_r < stream_end);

  always_comb begin
    phase_nxt = phase_r;
    hold_nxt  = hold_r;
    idx_nxt   = idx_r;
    pend_nxt  = pend_r;
    seen_nxt  = seen_r;
    do_text   = 1'b0;
    do_stop   = 1'b0;
    do_close  = 1'b0;
    push_c    = '0;

    if (live) begin
      unique case (phase_r)
        PH_WAIT_OPEN: begin
          if (byte_value == CH_OPEN2) begin
            phase_nxt = PH_ADC;
            idx_nxt   = '0;
            pend_nxt  = 1'b0;
          end
        end
        PH_ADC: begin
          if (!pend_r) begin
            hold_nxt = byte_value;
            pend_nxt = 1'b1;
          end else begin
            pend_nxt                   = 1'b0;
            push_c.push                = 1'b1;
            push_c.item.kind           = KIND_ADC;
            push_c.item.value          = {hold_r, byte_value};
            push_c.item.channel        = idx_r[ChanW-1:0];
            if (idx_r >= LastIdx) begin
              idx_nxt   = '0;
              phase_nxt = format_two ? PH_SEARCH : PH_SKIP;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
        end
        PH_SKIP: begin
          phase_nxt = PH_SEARCH;
        end
        PH_SEARCH: begin
          if (byte_value == CH_STOP) begin
            do_stop = 1'b1;
          end else if (byte_value == CH_DOLLAR) begin
            phase_nxt = PH_TEXT;
            do_text   = 1'b1;
          end
        end
        PH_TEXT: begin
          do_text = 1'b1;
        end
        PH_WAIT_CLOSE: begin
          if (byte_value == CH_CLOSE2) do_close = 1'b1;
        end
        default: begin
          // The unused phase code behaves as idle.
          phase_nxt = PH_IDLE;
          if (byte_value == CH_START) begin
            idx_nxt   = '0;
            pend_nxt  = 1'b0;
            phase_nxt = format_two ? PH_WAIT_OPEN : PH_ADC;
          end
        end
      endcase
    end

    if (do_text) begin
      if (byte_value == CH_CR || byte_value == CH_LF) begin
        // Line breaks inside the text are dropped.
      end else if (byte_value == CH_STOP) begin
        do_stop = 1'b1;
      end else begin
        push_c.push        = 1'b1;
        push_c.item.kind   = KIND_TEXT;
        push_c.item.value  = {{(ValueW-ByteW){1'b0}}, byte_value};
        if (byte_value == CH_STAR) push_c.item.separator_before = 1'b1;
        if (format_two && byte_value == CH_DOLLAR) begin
          if (seen_r) push_c.item.separator_before = 1'b1;
          seen_nxt = 1'b1;
        end
      end
    end

    if (do_stop) begin
      if (format_two) phase_nxt = PH_WAIT_CLOSE;
      else do_close = 1'b1;
    end

    if (do_close) begin
      phase_nxt        = PH_IDLE;
      seen_nxt         = 1'b0;
      push_c.push      = 1'b1;
      push_c.item      = '0;
      push_c.item.kind = KIND_END;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      hold_r  <= '0;
      idx_r   <= '0;
      pend_r  <= 1'b0;
      seen_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      hold_r  <= hold_nxt;
      idx_r   <= idx_nxt;
      pend_r  <= pend_nxt;
      seen_r  <= seen_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign push_o = push_c;

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= LastIdx)
    else $error("ADC index beyond the channel count");

  a_adc_source: assert property (@(posedge clk) disable iff (!rst_n)
    (push_c.push && push_c.item.kind == KIND_ADC) |-> (phase_r == PH_ADC && pend_r))
    else $error("ADC sample produced outside the low byte of a sample");

  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (push_c.push && push_c.item.kind == KIND_END) |=> (phase_r == PH_IDLE && !seen_r))
    else $error("record end did not return the parser to idle");

endmodule

// ===== hdl/slfp_fifo.sv =====
// ---------------------------------------------------------------------------
// slfp_fifo: short result queue
// Decouples the parser from the output stage so that a stalled output side
// holds up the parser only once the queue is full.
// ---------------------------------------------------------------------------
module slfp_fifo #(
  parameter int DEPTH = slfp_pkg::QueueDepthDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  slfp_pkg::push_t     push_i,
  input  logic                pop,
  output logic                full,
  output logic                empty,
  output slfp_pkg::result_t   head
);
  import slfp_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  result_t           mem [DEPTH];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   count_r, count_nxt;
  logic              wr_en;
  logic              rd_en;

  assign full  = (count_r == CntW'(DEPTH));
  assign empty = (count_r == '0);
  assign wr_en = push_i.push && !full;
  assign rd_en = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (wr_en) wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (rd_en) rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    count_nxt = count_r + CntW'(wr_en) - CntW'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr_r] <= push_i.item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign head = mem[rd_ptr_r];

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(DEPTH))
    else $error("queue fill count beyond its depth");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push_i.push)
    else $error("item pushed into a full queue");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && !rd_en) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not follow a push");

endmodule

// ===== hdl/slfp_back.sv =====
// ---------------------------------------------------------------------------
// slfp_back: output register stage
// Takes result items from the queue and holds each on the output stream
// until it is taken, packing the fields into tdata and tuser.
// ---------------------------------------------------------------------------
module slfp_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              empty,
  input  slfp_pkg::result_t                 head,
  output logic                              pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [slfp_pkg::OutDataW-1:0]     out_tdata,
  output logic [slfp_pkg::OutUserW-1:0]     out_tuser
);
  import slfp_pkg::*;

  logic    valid_r, valid_nxt;
  result_t item_r;

  // Load a new item whenever the register is free or being emptied.
  assign pop       = !empty && (!valid_r || out_tready);
  assign valid_nxt = pop ? 1'b1 : (out_tready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) item_r <= head;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {{(OutDataW-ValueW-ChanW-1){1'b0}}, item_r.separator_before,
                       item_r.channel, item_r.value};
  assign out_tuser  = item_r.kind;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: sensor log frame parser core
// Feeds log bytes into the deframer in bursts with random gaps, stalls the
// result side on a pattern of its own, and checks every result item field by
// field against the table's result or a byte-level framing model in this file.
// A short table of hand-picked bytes comes first, then random records.
// ---------------------------------------------------------------------------
module testbench;
  import slfp_pkg::*;

  localparam int ADC_CHANNELS      = 8;
  localparam int SENT_BYTES_TARGET = 1600;
  localparam int SETTLE_CYCLES     = 16;
  localparam int CYCLE_LIMIT       = 500000;

  localparam logic [CfgIdxW-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SPARE_B = 2'd3;
  localparam logic [CountW-1:0]  END_NEVER   = '1;
  localparam logic [ByteW-1:0]   CH_SPACE    = 8'h20;

  typedef enum logic [2:0] {
    PH_HUNT, PH_WAIT_OPEN, PH_SAMPLES, PH_STRAY, PH_SEEK_TEXT, PH_TEXT, PH_WAIT_CLOSE
  } frame_phase_t;

  typedef enum logic {ROW_BYTE, ROW_REG} row_op_t;

  typedef struct {
    row_op_t               op;
    logic [CfgIdxW-1:0]    idx;
    logic [CfgDataW-1:0]   data;
    bit                    typed;
    bit                    typed_has;
    result_t               typed_res;
  } stim_row_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic [OutUserW-1:0] out_tuser;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index  = '0;
  logic [CfgDataW-1:0] cfg_data   = '0;

  // Shadow of the deframer: registers and parse state.
  logic                fmt_two;
  logic [CountW-1:0]   stream_end_reg;
  frame_phase_t        phase;
  logic [ByteW-1:0]    high_hold;
  logic [AdcIdxW-1:0]  sample_idx;
  logic                low_pending;
  logic                dollar_seen;
  logic [CountW-1:0]   byte_count;

  result_t             expected_results[$];
  stim_row_t           directed_rows[$];
  logic [ByteW-1:0]    frame_bytes[$];

  int                  mismatch_count = 0;
  int                  sent_bytes     = 0;
  int                  burst_left     = 0;
  bit                  bursty         = 1'b1;
  int unsigned         cycle_count    = 0;
  int                  ready_mode     = 0;

  sensor_log_frame_parser_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void deframer_reset();
    fmt_two        = 1'b1;
    stream_end_reg = END_NEVER;
    phase          = PH_HUNT;
    high_hold      = '0;
    sample_idx     = '0;
    low_pending    = 1'b0;
    dollar_seen    = 1'b0;
    byte_count     = '0;
  endfunction

  function automatic bit record_end(output result_t r);
    phase       = PH_HUNT;
    dollar_seen = 1'b0;
    r           = '0;
    r.kind      = KIND_END;
    return 1'b1;
  endfunction

  // In format 2 the record end waits for the closing mark.
  function automatic bit stop_byte(output result_t r);
    r = '0;
    if (fmt_two) begin
      phase = PH_WAIT_CLOSE;
      return 1'b0;
    end
    return record_end(r);
  endfunction

  function automatic bit text_byte(input logic [ByteW-1:0] c, output result_t r);
    r = '0;
    if (c == CH_CR || c == CH_LF) return 1'b0;
    if (c == CH_STOP) return stop_byte(r);
    r.kind             = KIND_TEXT;
    r.value            = {8'h00, c};
    r.separator_before = (c == CH_STAR);
    // Format 2 flags every dollar after the first one of the record.
    if (fmt_two && c == CH_DOLLAR) begin
      if (dollar_seen) r.separator_before = 1'b1;
      dollar_seen = 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic bit deframe_byte(input logic [ByteW-1:0] c, output result_t r);
    logic [CountW-1:0] pos;
    bit                hit;
    pos = byte_count;
    hit = 1'b0;
    r   = '0;
    if (byte_count != END_NEVER) byte_count++;
    if (pos >= stream_end_reg) return 1'b0;
    case (phase)
      PH_WAIT_OPEN: begin
        if (c == CH_OPEN2) begin
          phase       = PH_SAMPLES;
          sample_idx  = '0;
          low_pending = 1'b0;
        end
      end
      PH_SAMPLES: begin
        if (!low_pending) begin
          high_hold   = c;
          low_pending = 1'b1;
        end else begin
          low_pending = 1'b0;
          r.kind      = KIND_ADC;
          r.value     = {high_hold, c};
          r.channel   = sample_idx[ChanW-1:0];
          hit         = 1'b1;
          if (sample_idx + 1 >= ADC_CHANNELS) begin
            sample_idx = '0;
            phase      = fmt_two ? PH_SEEK_TEXT : PH_STRAY;
          end else begin
            sample_idx = sample_idx + 1'b1;
          end
        end
      end
      PH_STRAY: phase = PH_SEEK_TEXT;
      PH_SEEK_TEXT: begin
        if (c == CH_STOP) begin
          hit = stop_byte(r);
        end else if (c == CH_DOLLAR) begin
          phase = PH_TEXT;
          hit   = text_byte(c, r);
        end
      end
      PH_TEXT: hit = text_byte(c, r);
      PH_WAIT_CLOSE: begin
        if (c == CH_CLOSE2) hit = record_end(r);
      end
      default: begin
        phase = PH_HUNT;
        if (c == CH_START) begin
          sample_idx  = '0;
          low_pending = 1'b0;
          phase       = fmt_two ? PH_WAIT_OPEN : PH_SAMPLES;
        end
      end
    endcase
    return hit;
  endfunction

  function automatic void add_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    stim_row_t row;
    row       = '{op: ROW_REG, default: '0};
    row.idx   = idx;
    row.data  = data;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_byte(input logic [ByteW-1:0] b);
    stim_row_t row;
    row      = '{op: ROW_BYTE, default: '0};
    row.data = {24'h0, b};
    directed_rows.push_back(row);
  endfunction

  // A byte whose outcome is plain to see: no result, or the result given.
  function automatic void add_typed(input logic [ByteW-1:0] b, input bit has,
                                    input logic [KindW-1:0] kind, input logic [ValueW-1:0] value,
                                    input logic [ChanW-1:0] chan, input logic sep);
    stim_row_t row;
    row                            = '{op: ROW_BYTE, default: '0};
    row.data                       = {24'h0, b};
    row.typed                      = 1'b1;
    row.typed_has                  = has;
    row.typed_res.kind             = kind;
    row.typed_res.value            = value;
    row.typed_res.channel          = chan;
    row.typed_res.separator_before = sep;
    directed_rows.push_back(row);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic send_byte(input logic [ByteW-1:0] b, input bit predicted);
    int      gap;
    result_t r;
    bit      has;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap        = bursty ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_bytes++;
    has = deframe_byte(b, r);
    if (predicted && has) expected_results.push_back(r);
  endtask

  // Leaves cfg_valid high; the caller lowers it after its last write.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_FORMAT_TWO) fmt_two = data[0];
    else if (idx == REG_STREAM_END) stream_end_reg = data;
  endtask

  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic build_record();
    logic [ByteW-1:0] b;
    int               pick;
    frame_bytes.delete();
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        b = ByteW'($urandom_range(0, 255));
        frame_bytes.push_back(b == CH_START ? CH_SPACE : b);
      end
    end
    frame_bytes.push_back(CH_START);
    if (fmt_two) begin
      repeat ($urandom_range(0, 2)) begin
        b = $urandom_range(0, 1) ? CH_START : ByteW'($urandom_range(0, 255));
        frame_bytes.push_back(b == CH_OPEN2 ? CH_START : b);
      end
      frame_bytes.push_back(CH_OPEN2);
    end
    repeat (2 * ADC_CHANNELS) frame_bytes.push_back(ByteW'($urandom_range(0, 255)));
    if (!fmt_two) frame_bytes.push_back(ByteW'($urandom_range(0, 255)));
    repeat ($urandom_range(0, 3)) begin
      b = ByteW'($urandom_range(0, 255));
      frame_bytes.push_back((b == CH_STOP || b == CH_DOLLAR) ? CH_SPACE : b);
    end
    if ($urandom_range(0, 4) != 0) begin
      frame_bytes.push_back(CH_DOLLAR);
      repeat ($urandom_range(0, 24)) begin
        pick = $urandom_range(0, 9);
        case (pick)
          0:       b = CH_CR;
          1:       b = CH_LF;
          2:       b = CH_STAR;
          3:       b = CH_DOLLAR;
          4:       b = ByteW'($urandom_range(0, 255));
          default: b = ByteW'($urandom_range(8'h20, 8'h7E));
        endcase
        frame_bytes.push_back(b == CH_STOP ? CH_SPACE : b);
      end
    end
    frame_bytes.push_back(CH_STOP);
    if (fmt_two) begin
      repeat ($urandom_range(0, 2)) begin
        b = ByteW'($urandom_range(0, 255));
        frame_bytes.push_back(b == CH_CLOSE2 ? CH_START : b);
      end
      frame_bytes.push_back(CH_CLOSE2);
    end
  endtask

  // Result side: stall pattern and comparison with the oldest expectation.
  always @(posedge clk) begin : result_side
    result_t want;
    cycle_count++;
    if (cycle_count % 128 == 0) ready_mode = $urandom_range(0, 3);
    case (ready_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= (cycle_count % 4 == 0);
      default: out_tready <= ((cycle_count / 16) % 2 == 0);
    endcase
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result kind %0d value %h with nothing expected",
                                  out_tuser, out_tdata[15:0]));
      end else begin
        want = expected_results.pop_front();
        if (out_tuser !== want.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", out_tuser, want.kind));
        if (out_tdata[15:0] !== want.value)
          report_mismatch($sformatf("value %h, expected %h", out_tdata[15:0], want.value));
        if (out_tdata[18:16] !== want.channel)
          report_mismatch($sformatf("channel %0d, expected %0d", out_tdata[18:16], want.channel));
        if (out_tdata[19] !== want.separator_before)
          report_mismatch($sformatf("separator %b, expected %b", out_tdata[19],
                                    want.separator_before));
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int pick;
    int keep;
    deframer_reset();

    // Unused register indexes must change nothing.
    add_reg(REG_SPARE_A, '0);
    add_reg(REG_SPARE_B, '0);
    // Format 2 record; a second start byte while waiting for the open mark is ignored.
    add_typed(CH_START, 1'b0, KIND_ADC, 16'h0, 3'd0, 1'b0);
    add_typed(CH_START, 1'b0, KIND_ADC, 16'h0, 3'd0, 1'b0);
    add_typed(CH_OPEN2, 1'b0, KIND_ADC, 16'h0, 3'd0, 1'b0);
    add_typed(8'hFF, 1'b0, KIND_ADC, 16'h0, 3'd0, 1'b0);
    add_typed(8'hFF, 1'b1, KIND_ADC, 16'hFFFF, 3'd0, 1'b0);
    add_typed(8'h00, 1'b0, KIND_ADC, 16'h0, 3'd0, 1'b0);
    add_typed(8'h00, 1'b1, KIND_ADC, 16'h0000, 3'd1, 1'b0);
    add_typed(8'h80, 1'b0, KIND_ADC, 16'h0, 3'd0, 1'b0);
    add_typed(8'h01, 1'b1, KIND_ADC, 16'h8001, 3'd2, 1'b0);
    add_byte(8'h12);
    add_byte(8'h34);
    add_byte(8'h56);
    add_byte(8'h78);
    add_byte(8'h9A);
    add_byte(8'hBC);
    add_byte(8'hDE);
    add_byte(8'hF0);
    add_byte(8'h7F);
    add_byte(8'hFE);
    // Search ignores ordinary bytes; text then starts at the dollar.
    add_typed(8'h41, 1'b0, KIND_ADC, 16'h0, 3'd0, 1'b0);
    add_typed(CH_DOLLAR, 1'b1, KIND_TEXT, 16'h0024, 3'd0, 1'b0);
    add_typed(CH_DOLLAR, 1'b1, KIND_TEXT, 16'h0024, 3'd0, 1'b1);
    // Format switched inside the text: the dollar rule of format 1 applies at once.
    add_reg(REG_FORMAT_TWO, 32'd0);
    add_typed(CH_DOLLAR, 1'b1, KIND_TEXT, 16'h0024, 3'd0, 1'b0);
    add_typed(CH_CR, 1'b0, KIND_ADC, 16'h0, 3'd0, 1'b0);
    add_typed(CH_LF, 1'b0, KIND_ADC, 16'h0, 3'd0, 1'b0);
    add_typed(CH_STAR, 1'b1, KIND_TEXT, 16'h002A, 3'd0, 1'b1);
    add_reg(REG_FORMAT_TWO, 32'd1);
    add_typed(CH_STOP, 1'b0, KIND_ADC, 16'h0, 3'd0, 1'b0);
    add_typed(CH_START, 1'b0, KIND_ADC, 16'h0, 3'd0, 1'b0);
    add_typed(CH_CLOSE2, 1'b1, KIND_END, 16'h0, 3'd0, 1'b0);
    // With the end offset at zero every byte is dropped.
    add_reg(REG_STREAM_END, '0);
    add_typed(CH_START, 1'b0, KIND_ADC, 16'h0, 3'd0, 1'b0);
    add_reg(REG_STREAM_END, END_NEVER);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].op == ROW_REG) begin
        wait_quiet();
        write_reg(directed_rows[i].idx, directed_rows[i].data);
        cfg_valid <= 1'b0;
      end else begin
        send_byte(directed_rows[i].data[ByteW-1:0], !directed_rows[i].typed);
        if (directed_rows[i].typed && directed_rows[i].typed_has)
          expected_results.push_back(directed_rows[i].typed_res);
      end
    end

    while (sent_bytes < SENT_BYTES_TARGET) begin
      wait_quiet();
      write_reg(REG_FORMAT_TWO, CfgDataW'($urandom_range(0, 1)));
      pick = $urandom_range(0, 19);
      if (pick < 12) write_reg(REG_STREAM_END, END_NEVER);
      else if (pick < 16) write_reg(REG_STREAM_END, byte_count + $urandom_range(8, 160));
      else if (pick == 16) write_reg(REG_STREAM_END, '0);
      else if (pick == 17) write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom());
      cfg_valid <= 1'b0;
      bursty = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 4)) begin
        build_record();
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          frame_bytes.delete();
          repeat ($urandom_range(1, 12)) frame_bytes.push_back(ByteW'($urandom_range(0, 255)));
        end else if (pick == 1) begin
          // Record cut short; whatever follows lands in the middle of it.
          keep = $urandom_range(1, frame_bytes.size());
          while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
        end
        foreach (frame_bytes[i]) send_byte(frame_bytes[i], 1'b1);
      end
    end

    wait_quiet();
    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/slfp_pkg.sv
hdl/slfp_front.sv
hdl/slfp_fifo.sv
hdl/slfp_back.sv
hdl/sensor_log_frame_parser_core.sv
sim/testbench.sv
